// ----- rtl/tjb_pkg.sv -----
package tjb_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int TIME_W  = 32;
    localparam int TAG_W   = 16;
    localparam int CNT_W   = 32;
    localparam int DELAY_W = 16;
    localparam int LIMIT_W = 7;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [DELAY_W-1:0] DELAY_RST = DELAY_W'(60);
    localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(64);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DELAY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT  = CFG_IDX_W'(1);

    // action codes, anything else clears
    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;

    // result status codes
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_LATE    = 3'd2;
    localparam logic [2:0] ST_POPPED  = 3'd3;
    localparam logic [2:0] ST_NOT_DUE = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;
    localparam logic [2:0] ST_CLEARED = 3'd6;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] frame_time;
        logic [TAG_W-1:0]  frame_tag;
        logic [TIME_W-1:0] local_now;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [TIME_W-1:0] out_time;
        logic [TAG_W-1:0]  out_tag;
        logic [CNT_W-1:0]  pushed_count;
        logic [CNT_W-1:0]  late_count;
        logic [CNT_W-1:0]  dropped_count;
        logic [CNT_W-1:0]  popped_count;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] value;
    } t_cfg_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DROP,
        S_DUE,
        S_RESP
    } t_state;

    typedef enum logic [1:0] {
        CH_HOLD,
        CH_INSERT,
        CH_SHIFT
    } t_chain_op;

    typedef struct packed {
        t_chain_op         op;
        logic [TIME_W-1:0] time_val;
        logic [TAG_W-1:0]  tag_val;
    } t_cell_ctl;

endpackage

// ----- rtl/tjb_if.sv -----
interface tjb_in_if import tjb_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tjb_out_if import tjb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tjb_cfg_if import tjb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tjb_cell.sv -----
module tjb_cell
    import tjb_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic              i_occ,
    input  logic              i_tail,
    input  logic              i_left_gt,
    input  logic [TIME_W-1:0] i_left_time,
    input  logic [TAG_W-1:0]  i_left_tag,
    input  logic [TIME_W-1:0] i_right_time,
    input  logic [TAG_W-1:0]  i_right_tag,
    output logic [TIME_W-1:0] o_time,
    output logic [TAG_W-1:0]  o_tag,
    output logic              o_gt
);

    logic [TIME_W-1:0] r_time;
    logic [TAG_W-1:0]  r_tag;

    // strictly greater keeps equal timestamps in arrival order
    assign o_gt   = i_occ && (r_time > i_ctl.time_val);
    assign o_time = r_time;
    assign o_tag  = r_tag;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CH_INSERT: begin
                if (i_left_gt) begin
                    r_time <= i_left_time;
                    r_tag  <= i_left_tag;
                end else if (o_gt || i_tail) begin
                    r_time <= i_ctl.time_val;
                    r_tag  <= i_ctl.tag_val;
                end
            end
            CH_SHIFT: begin
                r_time <= i_right_time;
                r_tag  <= i_right_tag;
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- rtl/tjb_chain.sv -----
module tjb_chain
    import tjb_pkg::*;
#(
    parameter int NCELL = DEPTH_DEF + 1,
    parameter int CW    = $clog2(DEPTH_DEF + 2)
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [CW-1:0]     i_count,
    output logic [TIME_W-1:0] o_front_time,
    output logic [TAG_W-1:0]  o_front_tag
);

    logic [TIME_W-1:0] w_time [NCELL];
    logic [TAG_W-1:0]  w_tag  [NCELL];
    logic              w_gt   [NCELL];

    for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
        logic              w_left_gt;
        logic [TIME_W-1:0] w_left_time;
        logic [TAG_W-1:0]  w_left_tag;
        logic [TIME_W-1:0] w_right_time;
        logic [TAG_W-1:0]  w_right_tag;

        if (gi == 0) begin : g_head
            assign w_left_gt   = 1'b0;
            assign w_left_time = '0;
            assign w_left_tag  = '0;
        end else begin : g_mid
            assign w_left_gt   = w_gt[gi-1];
            assign w_left_time = w_time[gi-1];
            assign w_left_tag  = w_tag[gi-1];
        end

        if (gi == NCELL - 1) begin : g_last
            assign w_right_time = w_time[gi];
            assign w_right_tag  = w_tag[gi];
        end else begin : g_inner
            assign w_right_time = w_time[gi+1];
            assign w_right_tag  = w_tag[gi+1];
        end

        tjb_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_occ        (i_count > CW'(gi)),
            .i_tail       (i_count == CW'(gi)),
            .i_left_gt    (w_left_gt),
            .i_left_time  (w_left_time),
            .i_left_tag   (w_left_tag),
            .i_right_time (w_right_time),
            .i_right_tag  (w_right_tag),
            .o_time       (w_time[gi]),
            .o_tag        (w_tag[gi]),
            .o_gt         (w_gt[gi])
        );
    end

    assign o_front_time = w_time[0];
    assign o_front_tag  = w_tag[0];

endmodule

// ----- rtl/timestamp_jitter_buffer.sv -----
// stored push: EXEC inserts, then DROP shifts out one frame per overflow drop, then RESP
// late push, clear and pop on an empty buffer: EXEC then RESP; pop of a frame: EXEC, DUE, RESP
// one item at a time: a new item is taken only in IDLE, and a stalled output holds RESP
// a sorted row of DEPTH+1 cells does an insert or a shift toward the head per cycle
// a finished result waits in the output register while the next item is taken
// synchronous active-low reset clears count, base, counters and registers to defaults
module timestamp_jitter_buffer
    import tjb_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tjb_in_if.sink   i_in,
    tjb_out_if.source o_out,
    tjb_cfg_if.sink  i_cfg
);

    localparam int CW = $clog2(DEPTH + 2);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    t_state r_state, n_state;

    t_in_item          r_item;
    logic [DELAY_W-1:0] r_delay;
    logic [LIMIT_W-1:0] r_limit;

    logic [CW-1:0]     r_count, n_count;
    logic              r_base_valid, n_base_valid;
    logic [TIME_W-1:0] r_base_media, n_base_media;
    logic [TIME_W-1:0] r_base_local, n_base_local;
    logic [TIME_W-1:0] r_last_rel, n_last_rel;
    logic [CNT_W-1:0]  r_pushed, n_pushed;
    logic [CNT_W-1:0]  r_late, n_late;
    logic [CNT_W-1:0]  r_dropped, n_dropped;
    logic [CNT_W-1:0]  r_popped, n_popped;

    logic [2:0]        r_status, n_status;
    logic              r_drop_seen, n_drop_seen;
    logic [TIME_W-1:0] r_otime, n_otime;
    logic [TAG_W-1:0]  r_otag, n_otag;
    logic [TIME_W:0]   r_due_a, n_due_a;
    logic [TIME_W-1:0] r_diff, n_diff;

    logic      r_ovalid, n_ovalid;
    t_out_item r_out, n_out;

    t_cell_ctl         w_ctl;
    logic [TIME_W-1:0] w_front_time;
    logic [TAG_W-1:0]  w_front_tag;

    logic [LW-1:0]        w_lim;
    logic [DELAY_W-1:0]   w_delay_eff;
    logic [TIME_W+1:0]    w_due;
    logic                 w_in_acc;
    logic                 w_out_free;

    tjb_chain #(
        .NCELL (DEPTH + 1),
        .CW    (CW)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_count      (r_count),
        .o_front_time (w_front_time),
        .o_front_tag  (w_front_tag)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_out;
    assign w_out_free  = !r_ovalid || o_out.ready;

    always_comb begin
        if (r_limit == '0) begin
            w_lim = LW'(1);
        end else if (LW'(r_limit) > LW'(DEPTH)) begin
            w_lim = LW'(DEPTH);
        end else begin
            w_lim = LW'(r_limit);
        end
        w_delay_eff = (r_delay == '0) ? DELAY_W'(1) : r_delay;
        w_due       = (TIME_W+2)'(r_due_a) + (TIME_W+2)'(r_diff);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_item.action == ACT_PUSH) begin
                    n_state = (r_item.frame_time <= r_last_rel) ? S_RESP : S_DROP;
                end else if (r_item.action == ACT_POP) begin
                    n_state = (r_count == '0 || !r_base_valid) ? S_RESP : S_DUE;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_DROP: begin
                if (LW'(r_count) <= w_lim) begin
                    n_state = S_RESP;
                end
            end
            S_DUE: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count      = r_count;
        n_base_valid = r_base_valid;
        n_base_media = r_base_media;
        n_base_local = r_base_local;
        n_last_rel   = r_last_rel;
        n_pushed     = r_pushed;
        n_late       = r_late;
        n_dropped    = r_dropped;
        n_popped     = r_popped;
        n_status     = r_status;
        n_drop_seen  = r_drop_seen;
        n_otime      = r_otime;
        n_otag       = r_otag;
        n_due_a      = r_due_a;
        n_diff       = r_diff;
        n_ovalid     = r_ovalid;
        n_out        = r_out;
        w_ctl.op       = CH_HOLD;
        w_ctl.time_val = r_item.frame_time;
        w_ctl.tag_val  = r_item.frame_tag;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                n_otime     = '0;
                n_otag      = '0;
                n_drop_seen = 1'b0;
                if (r_item.action == ACT_PUSH) begin
                    // first push after reset or clear fixes the base, late or not
                    if (!r_base_valid) begin
                        n_base_valid = 1'b1;
                        n_base_media = r_item.frame_time;
                        n_base_local = r_item.local_now;
                    end
                    if (r_item.frame_time <= r_last_rel) begin
                        n_late   = r_late + CNT_W'(1);
                        n_status = ST_LATE;
                    end else begin
                        w_ctl.op = CH_INSERT;
                        n_count  = r_count + CW'(1);
                        n_pushed = r_pushed + CNT_W'(1);
                    end
                end else if (r_item.action == ACT_POP) begin
                    n_status = ST_EMPTY;
                    n_due_a  = (TIME_W+1)'(r_base_local) + (TIME_W+1)'(w_delay_eff);
                    n_diff   = (w_front_time >= r_base_media) ?
                               (w_front_time - r_base_media) : '0;
                end else begin
                    n_count      = '0;
                    n_base_valid = 1'b0;
                    n_base_media = '0;
                    n_base_local = '0;
                    n_last_rel   = '0;
                    n_pushed     = '0;
                    n_late       = '0;
                    n_dropped    = '0;
                    n_popped     = '0;
                    n_status     = ST_CLEARED;
                end
            end
            S_DROP: begin
                if (LW'(r_count) > w_lim) begin
                    w_ctl.op    = CH_SHIFT;
                    n_count     = r_count - CW'(1);
                    n_dropped   = r_dropped + CNT_W'(1);
                    n_drop_seen = 1'b1;
                end else begin
                    n_status = r_drop_seen ? ST_DROPPED : ST_STORED;
                end
            end
            S_DUE: begin
                if ((TIME_W+2)'(r_item.local_now) < w_due) begin
                    n_status = ST_NOT_DUE;
                end else begin
                    w_ctl.op   = CH_SHIFT;
                    n_count    = r_count - CW'(1);
                    n_last_rel = w_front_time;
                    n_popped   = r_popped + CNT_W'(1);
                    n_otime    = w_front_time;
                    n_otag     = w_front_tag;
                    n_status   = ST_POPPED;
                end
            end
            S_RESP: begin
                if (w_out_free) begin
                    n_ovalid            = 1'b1;
                    n_out.status        = r_status;
                    n_out.out_time      = r_otime;
                    n_out.out_tag       = r_otag;
                    n_out.pushed_count  = r_pushed;
                    n_out.late_count    = r_late;
                    n_out.dropped_count = r_dropped;
                    n_out.popped_count  = r_popped;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_delay      <= DELAY_RST;
            r_limit      <= LIMIT_RST;
            r_count      <= '0;
            r_base_valid <= 1'b0;
            r_base_media <= '0;
            r_base_local <= '0;
            r_last_rel   <= '0;
            r_pushed     <= '0;
            r_late       <= '0;
            r_dropped    <= '0;
            r_popped     <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_base_valid <= n_base_valid;
            r_base_media <= n_base_media;
            r_base_local <= n_base_local;
            r_last_rel   <= n_last_rel;
            r_pushed     <= n_pushed;
            r_late       <= n_late;
            r_dropped    <= n_dropped;
            r_popped     <= n_popped;
            r_ovalid     <= n_ovalid;
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    CFG_TARGET_DELAY: r_delay <= i_cfg.data.value;
                    CFG_FRAME_LIMIT:  r_limit <= i_cfg.data.value[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= i_in.data;
        end
        r_status    <= n_status;
        r_drop_seen <= n_drop_seen;
        r_otime     <= n_otime;
        r_otag      <= n_otag;
        r_due_a     <= n_due_a;
        r_diff      <= n_diff;
        r_out       <= n_out;
    end

endmodule

// ----- rtl/tjb_checker.sv -----
module tjb_checker
    import tjb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    // protocol: a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output item changed while stalled");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_data.status <= ST_CLEARED)
        else $error("status code out of range");

    a_zero_unless_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != ST_POPPED |->
            i_out_data.out_time == '0 && i_out_data.out_tag == '0)
        else $error("frame fields set without a pop");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status == ST_CLEARED |->
            i_out_data.pushed_count == '0 && i_out_data.late_count == '0 &&
            i_out_data.dropped_count == '0 && i_out_data.popped_count == '0)
        else $error("counters not zero after clear");

endmodule

bind timestamp_jitter_buffer tjb_checker u_tjb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
